### design/lfo_waveform_mixer_macros.svh
// ---------------------------------------------------------------------------
// lfo_waveform_mixer assertion macros
// Shared property wrappers for the oscillator checks.
// ---------------------------------------------------------------------------
`ifndef LFO_WAVEFORM_MIXER_MACROS_SVH
`define LFO_WAVEFORM_MIXER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFO_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFO_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lfo_pkg.sv
// ---------------------------------------------------------------------------
// lfo_pkg
// Constants and helper functions for the low-frequency oscillator.
// ---------------------------------------------------------------------------
package lfo_pkg;

    localparam int DEF_PHASE_BITS  = 32;
    localparam int DEF_OUTPUT_BITS = 16;

    localparam int RATE_W   = 16;
    localparam int MASK_W   = 5;
    localparam int SCALE_W  = 26;
    localparam int CLAMP_W  = 15;
    localparam int COUNT_W  = 3;
    localparam int RECIP_W  = 17;
    localparam int NOISE_W  = 32;
    localparam int SCALE_FRAC_BITS = 48;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 26'd5864062;
    localparam logic [RATE_W-1:0]  RATE_MIN    = 16'd10;
    localparam logic [RATE_W-1:0]  RATE_MAX    = 16'd30000;
    localparam logic [NOISE_W-1:0] NOISE_SEED  = 32'h7f4a7c15;

    typedef logic [RECIP_W-1:0] recip_t;

    // Q16 reciprocal of the number of selected waveforms.
    function automatic recip_t recip_q16(input logic [COUNT_W-1:0] count);
        recip_t r;
        case (count)
            3'd1:    r = 17'd65536;
            3'd2:    r = 17'd32768;
            3'd3:    r = 17'd21845;
            3'd4:    r = 17'd16384;
            3'd5:    r = 17'd13107;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // One step of the xorshift32 generator.
    function automatic logic [NOISE_W-1:0] xorshift32(input logic [NOISE_W-1:0] s_in);
        logic [NOISE_W-1:0] s;
        s = s_in;
        s = s ^ (s << 13);
        s = s ^ (s >> 17);
        s = s ^ (s << 5);
        return s;
    endfunction

endpackage

### design/lfo_waveform_mixer.sv
// ---------------------------------------------------------------------------
// lfo_waveform_mixer
// Phase-accumulator LFO that averages the selected waveforms per sample tick.
// ---------------------------------------------------------------------------
// Each accepted item is one sample tick. The block takes one item every clock
// while the output is not stalled by m_axis_tready, and delivers its result
// through the input register, then the result register; the sustained rate of
// one item per cycle is set by the phase accumulator loop, which closes through
// a single rate-times-scale multiply and one add in the stage between the two
// registers. The result is formed from the phase before that tick's advance,
// and a new held value taken at a phase wrap is first seen on the following tick.
`include "lfo_waveform_mixer_macros.svh"

module lfo_waveform_mixer
    import lfo_pkg::*;
#(
    parameter int PHASE_BITS  = DEF_PHASE_BITS,
    parameter int OUTPUT_BITS = DEF_OUTPUT_BITS,
    localparam int OUT_TDATA_W = ((OUTPUT_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [SCALE_W-1:0]     cfg_wr_data,    // phase_step_scale

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [RATE_W-1:0]      s_axis_tdata,   // [15:0] rate_millihertz
    input  logic [MASK_W-1:0]      s_axis_tuser,   // [4:0] waveform_mask

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [OUTPUT_BITS-1:0] lfo_value
);

    localparam int FRAC     = OUTPUT_BITS - 1;
    localparam int SUM_W    = OUTPUT_BITS + 3;
    localparam int PROD_W   = SUM_W + RECIP_W + 1;
    localparam int MUL_W    = CLAMP_W + SCALE_W;
    localparam int INC_SHIFT = SCALE_FRAC_BITS - PHASE_BITS;

    localparam logic signed [SUM_W-1:0]  FS_S    = SUM_W'(1) << FRAC;
    localparam logic signed [SUM_W-1:0]  HALF_S  = SUM_W'(1) << (FRAC - 1);
    localparam logic signed [PROD_W-1:0] RND_BIAS = PROD_W'(1) << 15;
    localparam logic signed [PROD_W-1:0] SAT_HI  = (PROD_W'(1) << FRAC) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] SAT_LO  = -(PROD_W'(1) << FRAC);

    // Control and state registers.
    logic                    in_valid_reg;
    logic                    out_valid_reg;
    logic [PHASE_BITS-1:0]   phase_reg, phase_next;
    logic signed [OUTPUT_BITS-1:0] held_reg, held_next;
    logic [NOISE_W-1:0]      noise_reg, noise_next;
    logic [SCALE_W-1:0]      scale_reg;

    // Payload registers.
    logic [RATE_W-1:0]       rate_reg;
    logic [MASK_W-1:0]       mask_reg;
    logic [OUTPUT_BITS-1:0]  value_reg, value_next;

    logic out_ready;
    logic advance;
    logic in_load;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    // ---------------- Waveforms and average ----------------
    logic [FRAC-1:0]          p;
    logic signed [SUM_W-1:0]  pw, p_offset, adist;
    logic signed [SUM_W-1:0]  saw_up, tri_w, square_w, saw_dn, hold_w;
    logic signed [SUM_W-1:0]  sum;
    logic [COUNT_W-1:0]       count;
    logic signed [PROD_W-1:0] prod, biased, rounded, clipped;

    assign p        = phase_reg[PHASE_BITS-1 -: FRAC];
    assign pw       = SUM_W'({1'b0, p});
    assign p_offset = pw - HALF_S;
    assign adist    = p_offset[SUM_W-1] ? -p_offset : p_offset;

    assign saw_up   = (pw <<< 1) - FS_S;
    assign tri_w    = FS_S - (adist <<< 2);
    assign square_w = p[FRAC-1] ? -FS_S : FS_S;
    assign saw_dn   = FS_S - (pw <<< 1);
    assign hold_w   = SUM_W'(held_reg);

    always_comb begin
        sum   = '0;
        count = '0;
        if (mask_reg[0]) begin
            sum   = sum + saw_up;
            count = count + COUNT_W'(1);
        end
        if (mask_reg[1]) begin
            sum   = sum + tri_w;
            count = count + COUNT_W'(1);
        end
        if (mask_reg[2]) begin
            sum   = sum + square_w;
            count = count + COUNT_W'(1);
        end
        if (mask_reg[3]) begin
            sum   = sum + saw_dn;
            count = count + COUNT_W'(1);
        end
        if (mask_reg[4]) begin
            sum   = sum + hold_w;
            count = count + COUNT_W'(1);
        end
    end

    // Round to nearest with ties upward: add half an LSB, then floor.
    assign prod    = PROD_W'(sum) * $signed({1'b0, recip_q16(count)});
    assign biased  = prod + RND_BIAS;
    assign rounded = biased >>> 16;

    always_comb begin
        if (rounded > SAT_HI) begin
            clipped = SAT_HI;
        end else if (rounded < SAT_LO) begin
            clipped = SAT_LO;
        end else begin
            clipped = rounded;
        end
        value_next = (count == '0) ? '0 : clipped[OUTPUT_BITS-1:0];
    end

    // ---------------- Phase advance ----------------
    logic [CLAMP_W-1:0]    rate_clamped;
    logic [MUL_W-1:0]      step_prod;
    logic [MUL_W-1:0]      step_shifted;
    logic [PHASE_BITS:0]   phase_sum;
    logic [NOISE_W-1:0]    noise_stepped;
    logic                  wrapped;

    always_comb begin
        if (rate_reg < RATE_MIN) begin
            rate_clamped = CLAMP_W'(RATE_MIN);
        end else if (rate_reg > RATE_MAX) begin
            rate_clamped = CLAMP_W'(RATE_MAX);
        end else begin
            rate_clamped = rate_reg[CLAMP_W-1:0];
        end
    end

    assign step_prod     = MUL_W'(rate_clamped) * MUL_W'(scale_reg);
    assign step_shifted  = step_prod >> INC_SHIFT;
    assign phase_sum     = {1'b0, phase_reg} + (PHASE_BITS + 1)'(step_shifted);
    assign wrapped       = phase_sum[PHASE_BITS];
    assign noise_stepped = xorshift32(noise_reg);

    always_comb begin
        phase_next = phase_reg;
        noise_next = noise_reg;
        held_next  = held_reg;
        if (advance) begin
            phase_next = phase_sum[PHASE_BITS-1:0];
            if (wrapped) begin
                noise_next = noise_stepped;
                // Top bits minus full scale is the same as inverting the top bit.
                held_next  = {~noise_stepped[NOISE_W-1],
                              noise_stepped[NOISE_W-2 -: OUTPUT_BITS-1]};
            end
        end
    end

    // ---------------- Registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            held_reg      <= '0;
            noise_reg     <= NOISE_SEED;
            scale_reg     <= SCALE_RESET;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
            phase_reg <= phase_next;
            held_reg  <= held_next;
            noise_reg <= noise_next;
            if (cfg_wr_en) begin
                scale_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            rate_reg <= s_axis_tdata;
            mask_reg <= s_axis_tuser;
        end
        if (advance) begin
            value_reg <= value_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(value_reg);

    // ---------------- Assertions ----------------
    `LFO_ASSERT_SAME(a_noise_nonzero, aclk, aresetn, 1'b1, noise_reg != '0,
        "noise generator reached the all-zero lockup state")
    `LFO_ASSERT_NEXT(a_state_holds, aclk, aresetn, !advance,
        $stable(phase_reg) && $stable(noise_reg) && $stable(held_reg),
        "oscillator state changed without an item advancing")
    `LFO_ASSERT_NEXT(a_empty_mask_zero, aclk, aresetn, advance && (mask_reg == '0),
        value_reg == '0, "empty waveform mask produced a nonzero value")
    `LFO_ASSERT_SAME(a_ready_when_drained, aclk, aresetn, !out_valid_reg,
        s_axis_tready, "input stalled while the result register was empty")

endmodule
